// ===== hw/rtl/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg: shared types for the typed slot pool
// Operation codes and the command record that travels from the front end
// through the command queue to the execution engine.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_COUNT = 2'd2,
    OP_GET   = 2'd3
  } op_e;

  // Classified command, one per accepted transaction
  typedef struct packed {
    op_e        op;
    logic [3:0] entity_type;
    logic [4:0] slot_index;
    logic [4:0] nth;
    logic       free_hit;     // slot_index names a slot that exists
  } cmd_t;

endpackage

// ===== hw/rtl/tsp_front.sv =====
// ----------------------------------------------------------------------------
// tsp_front: request intake and command queue
// Accepts start transactions, classifies them into commands and holds them
// in a two-entry queue until the engine takes them.
// ----------------------------------------------------------------------------
module tsp_front #(
  parameter int SLOTS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        func_i,
  input  logic [3:0]        entity_type_i,
  input  logic [4:0]        slot_index_i,
  input  logic [4:0]        nth_i,
  output logic              busy_o,
  output tsp_pkg::cmd_t     cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i
);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  tsp_pkg::cmd_t      queue_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  fill_q, fill_d;
  tsp_pkg::cmd_t      cmd_new;
  logic               push;
  logic               pop;

  // Classify the incoming request
  always_comb begin
    cmd_new.op          = tsp_pkg::op_e'(func_i);
    cmd_new.entity_type = entity_type_i;
    cmd_new.slot_index  = slot_index_i;
    cmd_new.nth         = nth_i;
    cmd_new.free_hit    = (32'(slot_index_i) < SLOTS);
  end

  // Queue control
  assign busy_o      = (fill_q == QCNT_W'(QDEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign push        = start_i && !busy_o;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== hw/rtl/tsp_engine.sv =====
// ----------------------------------------------------------------------------
// tsp_engine: slot pool state and command execution
// Holds the in-use bits and the type tag memory; carries out free directly, and
// allocate, count and get by scanning the pool one row of eight slots per cycle.
// ----------------------------------------------------------------------------
module tsp_engine #(
  parameter int SLOTS     = 32,
  parameter int TYPE_BITS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tsp_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  output logic          done_o,
  output logic          ok_o,
  output logic [4:0]    result_slot_o,
  output logic [5:0]    type_count_o
);

  localparam int LANES   = 8;
  localparam int LANE_W  = 3;
  localparam int ROWS    = (SLOTS + LANES - 1) / LANES;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W   = ROW_W + LANE_W;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int RANK_W  = ((CNT_W > 5) ? CNT_W : 5) + 1;
  localparam int FREE_W  = (SLOT_W > 5) ? SLOT_W : 5;
  localparam int RES_W   = (IDX_W > 5) ? IDX_W : 5;
  localparam int SAT_W   = (CNT_W > 6) ? CNT_W : 6;
  localparam int PAD_N   = ROWS * LANES;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [PAD_N-1:0] EXIST    = {PAD_N{1'b1}} >> (PAD_N - SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FREE,
    ST_ALLOC,
    ST_SCAN
  } state_e;

  state_e                              state_q;
  tsp_pkg::cmd_t                       cmd_q;
  logic [ROW_W-1:0]                    row_q;
  logic [ROW_W-1:0]                    dat_row_q;
  logic                                pend_q;
  logic                                issued_q;
  logic [CNT_W-1:0]                    seen_q;
  logic [SLOTS-1:0]                    used_q;
  logic                                done_q;
  logic                                ok_q;
  logic [4:0]                          slot_q;
  logic [5:0]                          cnt_q;

  logic [LANES-1:0][TYPE_BITS-1:0]     type_mem [ROWS];
  logic [LANES-1:0][TYPE_BITS-1:0]     rdata_q;

  logic [TYPE_BITS-1:0]                tag;
  logic [PAD_N-1:0]                    used_ext;
  logic [LANES-1:0]                    alloc_row;
  logic                                free_any;
  logic [LANE_W-1:0]                   free_lane;
  logic [IDX_W-1:0]                    alloc_idx;
  logic [RES_W-1:0]                    alloc_res;
  logic [LANES-1:0]                    dat_used;
  logic [LANES-1:0]                    dat_exist;
  logic [LANES-1:0]                    match;
  logic [LANE_W:0]                     pc;
  logic [CNT_W-1:0]                    seen_sum;
  logic [RANK_W-1:0]                   rank_ext;
  logic [RANK_W-1:0]                   pick_k;
  logic                                found;
  logic [LANE_W-1:0]                   get_lane;
  logic [IDX_W-1:0]                    get_idx;
  logic [RES_W-1:0]                    get_res;
  logic [FREE_W-1:0]                   free_ext;
  logic [SAT_W-1:0]                    tot_ext;
  logic [5:0]                          tot_sat;
  logic                                mem_we;

  // Lowest set lane of a row
  function automatic logic [LANE_W-1:0] first_set(input logic [LANES-1:0] v);
    logic [LANE_W-1:0] r;
    r = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = LANE_W'(i);
      end
    end
    return r;
  endfunction

  // Lane of the k-th set bit of a row, counting from lane 0
  function automatic logic [LANE_W-1:0] nth_set(input logic [LANES-1:0] v,
                                                input logic [LANE_W-1:0] k);
    logic [LANE_W-1:0] r;
    logic [LANE_W:0]   c;
    r = '0;
    c = '0;
    for (int i = 0; i < LANES; i++) begin
      if (v[i]) begin
        if (c == {1'b0, k}) begin
          r = LANE_W'(i);
        end
        c = c + 1'b1;
      end
    end
    return r;
  endfunction

  // Number of set lanes in a row
  function automatic logic [LANE_W:0] pop_row(input logic [LANES-1:0] v);
    logic [LANE_W:0] c;
    c = '0;
    for (int i = 0; i < LANES; i++) begin
      c = c + (LANE_W+1)'(v[i]);
    end
    return c;
  endfunction

  // Padding slots beyond the pool read as used so allocate never picks them
  assign tag      = TYPE_BITS'(cmd_q.entity_type);
  assign used_ext = ~EXIST | PAD_N'(used_q);

  // Allocate: first free lane of the current row
  assign alloc_row = used_ext[row_q*LANES +: LANES];
  assign free_any  = |(~alloc_row);
  assign free_lane = first_set(~alloc_row);
  assign alloc_idx = {row_q, free_lane};
  assign alloc_res = RES_W'(alloc_idx);
  assign mem_we    = (state_q == ST_ALLOC) && free_any;

  // Count and get: matches in the row returned by the tag memory
  assign dat_used  = used_ext[dat_row_q*LANES +: LANES];
  assign dat_exist = EXIST[dat_row_q*LANES +: LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      match[l] = dat_used[l] && dat_exist[l] && (rdata_q[l] == tag);
    end
  end

  assign pc       = pop_row(match);
  assign seen_sum = seen_q + CNT_W'(pc);
  assign rank_ext = RANK_W'(cmd_q.nth);
  assign found    = rank_ext < (RANK_W'(seen_q) + RANK_W'(pc));
  assign pick_k   = rank_ext - RANK_W'(seen_q);
  assign get_lane = nth_set(match, pick_k[LANE_W-1:0]);
  assign get_idx  = {dat_row_q, get_lane};
  assign get_res  = RES_W'(get_idx);
  assign tot_ext  = SAT_W'(seen_sum);
  assign tot_sat  = (tot_ext > SAT_W'(63)) ? 6'd63 : tot_ext[5:0];
  assign free_ext = FREE_W'(cmd_q.slot_index);

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  // Sequencer, pool flags and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmd_q     <= '0;
      row_q     <= '0;
      dat_row_q <= '0;
      pend_q    <= 1'b0;
      issued_q  <= 1'b0;
      seen_q    <= '0;
      used_q    <= '0;
      done_q    <= 1'b0;
      ok_q      <= 1'b0;
      slot_q    <= '0;
      cnt_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q    <= cmd_i;
            row_q    <= '0;
            pend_q   <= 1'b0;
            issued_q <= 1'b0;
            seen_q   <= '0;
            unique case (cmd_i.op) inside
              tsp_pkg::OP_ALLOC:                   state_q <= ST_ALLOC;
              tsp_pkg::OP_FREE:                    state_q <= ST_FREE;
              tsp_pkg::OP_COUNT, tsp_pkg::OP_GET:  state_q <= ST_SCAN;
              default:                             state_q <= ST_IDLE;
            endcase
          end
        end

        ST_FREE: begin
          if (cmd_q.free_hit) begin
            used_q[free_ext[SLOT_W-1:0]] <= 1'b0;
          end
          done_q  <= 1'b1;
          ok_q    <= 1'b0;
          slot_q  <= '0;
          cnt_q   <= '0;
          state_q <= ST_IDLE;
        end

        ST_ALLOC: begin
          if (free_any) begin
            used_q[alloc_idx[SLOT_W-1:0]] <= 1'b1;
            done_q  <= 1'b1;
            ok_q    <= 1'b1;
            slot_q  <= alloc_res[4:0];
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else if (row_q == LAST_ROW) begin
            // pool full
            done_q  <= 1'b1;
            ok_q    <= 1'b0;
            slot_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            row_q <= row_q + 1'b1;
          end
        end

        ST_SCAN: begin
          // read side: issue one row per cycle
          if (!issued_q) begin
            dat_row_q <= row_q;
            pend_q    <= 1'b1;
            if (row_q == LAST_ROW) begin
              issued_q <= 1'b1;
            end else begin
              row_q <= row_q + 1'b1;
            end
          end else begin
            pend_q <= 1'b0;
          end
          // data side: accumulate matches of the returned row
          if (pend_q) begin
            if ((cmd_q.op == tsp_pkg::OP_GET) && found) begin
              done_q  <= 1'b1;
              ok_q    <= 1'b1;
              slot_q  <= get_res[4:0];
              cnt_q   <= '0;
              state_q <= ST_IDLE;
            end else if (dat_row_q == LAST_ROW) begin
              done_q  <= 1'b1;
              ok_q    <= 1'b0;
              slot_q  <= '0;
              cnt_q   <= (cmd_q.op == tsp_pkg::OP_COUNT) ? tot_sat : 6'd0;
              state_q <= ST_IDLE;
            end else begin
              seen_q <= seen_sum;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Type tag memory: lane-enabled write, registered row read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      type_mem[row_q][free_lane] <= tag;
    end
    rdata_q <= type_mem[row_q];
  end

  assign done_o        = done_q;
  assign ok_o          = ok_q;
  assign result_slot_o = slot_q;
  assign type_count_o  = cnt_q;

endmodule

// ===== hw/rtl/typed_slot_pool.sv =====
// ----------------------------------------------------------------------------
// typed_slot_pool: pool of typed slots with allocate, free, count and get
// Top level: request intake with command queue, and the execution engine.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; busy_o rises only
// when the two-entry command queue is full. Every request yields exactly one
// result, shown for a single cycle with done_o high, in request order; the
// receiver must take it then. The engine scans the pool one row of eight slots
// per cycle: allocate scans the in-use bits, count and get read rows through
// the tag memory's single read port, and free needs no scan. The engine takes
// no new request from the queue before it is through with the current one.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module typed_slot_pool #(
  parameter int SLOTS     = 32,
  parameter int TYPE_BITS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] func_i,
  input  logic [3:0] entity_type_i,
  input  logic [4:0] slot_index_i,
  input  logic [4:0] nth_i,
  output logic       done_o,
  output logic       ok_o,
  output logic [4:0] result_slot_o,
  output logic [5:0] type_count_o
);

  tsp_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  // Intake and command queue
  tsp_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .func_i        (func_i),
    .entity_type_i (entity_type_i),
    .slot_index_i  (slot_index_i),
    .nth_i         (nth_i),
    .busy_o        (busy_o),
    .cmd_o         (cmd),
    .cmd_valid_o   (cmd_valid),
    .cmd_pop_i     (cmd_pop)
  );

  // Execution engine
  tsp_engine #(
    .SLOTS     (SLOTS),
    .TYPE_BITS (TYPE_BITS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cmd_valid_i   (cmd_valid),
    .cmd_pop_o     (cmd_pop),
    .done_o        (done_o),
    .ok_o          (ok_o),
    .result_slot_o (result_slot_o),
    .type_count_o  (type_count_o)
  );

`ifndef SYNTHESIS
  // A failed or non-searching transaction reports slot zero
  a_fail_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ok_o |-> result_slot_o == 5'd0)
    else $error("result_slot_o nonzero without ok_o");

  // A found slot never comes with a type count
  a_ok_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ok_o |-> type_count_o == 6'd0)
    else $error("type_count_o nonzero with ok_o");

  // An accepted request is in the queue on the next cycle
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> cmd_valid)
    else $error("accepted request missing from queue");

  // No result in the cycle after the engine takes a command
  a_pop_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |=> !done_o)
    else $error("result strobe right after command pop");
`endif

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the typed slot pool
// Drives allocate, free, count and get requests through the start/busy
// handshake. A directed table opens the run, then six phases of random
// traffic with different operation mixes and type spreads. A behavioral
// copy of the pool predicts each answer, and each done_o strobe is compared
// field by field with the oldest expected one (typed in for pinned rows).
// ----------------------------------------------------------------------------
module testbench;

  localparam int          POOL_SLOTS  = 32;
  localparam int          PHASE_ITEMS = 250;
  localparam int          PHASES      = 6;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 20;

  // One answer of the pool, as seen on the result ports
  typedef struct packed {
    logic       ok;
    logic [4:0] slot;
    logic [5:0] cnt;
  } pool_answer_t;

  // One row of the directed table
  typedef struct packed {
    tsp_pkg::op_e op;
    logic [3:0]   etype;
    logic [4:0]   sidx;
    logic [4:0]   nth;
    logic         pinned;   // answer typed into the row
    pool_answer_t want;
  } stim_row_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       start_i       = 1'b0;
  logic [1:0] func_i        = '0;
  logic [3:0] entity_type_i = '0;
  logic [4:0] slot_index_i  = '0;
  logic [4:0] nth_i         = '0;
  logic       busy_o;
  logic       done_o;
  logic       ok_o;
  logic [4:0] result_slot_o;
  logic [5:0] type_count_o;

  // Travels alongside the request fields, sampled at acceptance
  logic         drv_pinned = 1'b0;
  pool_answer_t drv_want   = '0;

  // Shadow pool and outstanding answers
  logic         pool_used [POOL_SLOTS];
  logic [3:0]   pool_tag  [POOL_SLOTS];
  pool_answer_t answer_q  [$];
  stim_row_t    stim_rows [$];

  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned n_op [4];
  int unsigned n_full     = 0;
  int unsigned n_hits     = 0;
  int unsigned peak_count = 0;
  pool_answer_t predicted;
  pool_answer_t seen_ans;
  pool_answer_t due_ans;

  typed_slot_pool #(
    .SLOTS    (POOL_SLOTS),
    .TYPE_BITS(4)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .entity_type_i(entity_type_i),
    .slot_index_i (slot_index_i),
    .nth_i        (nth_i),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .result_slot_o(result_slot_o),
    .type_count_o (type_count_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Apply one request to the shadow pool and return its answer
  function automatic pool_answer_t pool_apply(tsp_pkg::op_e op, logic [3:0] t,
                                              logic [4:0] idx, logic [4:0] rank);
    pool_answer_t a;
    int unsigned  seen;
    a    = '0;
    seen = 0;
    case (op)
      tsp_pkg::OP_ALLOC: begin
        for (int s = 0; s < POOL_SLOTS; s++) begin
          if (!pool_used[s]) begin
            pool_used[s] = 1'b1;
            pool_tag[s]  = t;
            a.ok         = 1'b1;
            a.slot       = 5'(s);
            break;
          end
        end
      end
      tsp_pkg::OP_FREE: begin
        if (int'(idx) < POOL_SLOTS) pool_used[idx] = 1'b0;
      end
      tsp_pkg::OP_COUNT: begin
        for (int s = 0; s < POOL_SLOTS; s++)
          if (pool_used[s] && pool_tag[s] == t) seen++;
        a.cnt = (seen > 63) ? 6'd63 : 6'(seen);
      end
      default: begin
        // rank counts matching in-use slots from the low end
        for (int s = 0; s < POOL_SLOTS; s++) begin
          if (pool_used[s] && pool_tag[s] == t) begin
            if (seen == int'(rank)) begin
              a.ok   = 1'b1;
              a.slot = 5'(s);
              break;
            end
            seen++;
          end
        end
      end
    endcase
    return a;
  endfunction

  // In-use slots carrying a tag, used to aim get ranks
  function automatic int unsigned tally_type(logic [3:0] t);
    int unsigned n;
    n = 0;
    for (int s = 0; s < POOL_SLOTS; s++)
      if (pool_used[s] && pool_tag[s] == t) n++;
    return n;
  endfunction

  // Some in-use slot if there is one, else any slot
  function automatic logic [4:0] pick_used_slot();
    int unsigned first;
    int unsigned s;
    first = $urandom_range(0, POOL_SLOTS - 1);
    for (int k = 0; k < POOL_SLOTS; k++) begin
      s = (first + k) % POOL_SLOTS;
      if (pool_used[s]) return 5'(s);
    end
    return 5'(first);
  endfunction

  // Idle cycles after a transaction: mostly none or short, a few long
  function automatic int unsigned gap_len(bit gaps_on);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic stim_row_t mk_row(tsp_pkg::op_e op, logic [3:0] t, logic [4:0] idx,
                                       logic [4:0] n, logic pin, logic ok,
                                       logic [4:0] slot, logic [5:0] cnt);
    stim_row_t r;
    r.op     = op;
    r.etype  = t;
    r.sidx   = idx;
    r.nth    = n;
    r.pinned = pin;
    r.want   = '{ok: ok, slot: slot, cnt: cnt};
    return r;
  endfunction

  // Hold one request until the pool takes it, then idle for the gap
  task automatic issue_request(tsp_pkg::op_e op, logic [3:0] t, logic [4:0] idx,
                               logic [4:0] n, logic pin, pool_answer_t want,
                               int unsigned gap);
    start_i       <= 1'b1;
    func_i        <= op;
    entity_type_i <= t;
    slot_index_i  <= idx;
    nth_i         <= n;
    drv_pinned    <= pin;
    drv_want      <= want;
    do @(posedge clk_i); while (busy_o);
    if (gap != 0) begin
      start_i       <= 1'b0;
      func_i        <= 2'($urandom);
      entity_type_i <= 4'($urandom);
      slot_index_i  <= 5'($urandom);
      nth_i         <= 5'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic check_field(string name, logic [5:0] want, logic [5:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d (cycle %0d)", name, want, got, cycles);
    end
  endtask

  // Predict at acceptance, check at every done strobe
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        seen_ans = '{ok: ok_o, slot: result_slot_o, cnt: type_count_o};
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with no request outstanding (cycle %0d)", cycles);
        end else begin
          due_ans = answer_q.pop_front();
          check_field("ok", 6'(due_ans.ok), 6'(seen_ans.ok));
          check_field("result_slot", 6'(due_ans.slot), 6'(seen_ans.slot));
          check_field("type_count", due_ans.cnt, seen_ans.cnt);
        end
      end
      if (start_i && !busy_o) begin
        predicted = pool_apply(tsp_pkg::op_e'(func_i), entity_type_i, slot_index_i, nth_i);
        answer_q.push_back(drv_pinned ? drv_want : predicted);
        n_op[func_i]++;
        if (tsp_pkg::op_e'(func_i) == tsp_pkg::OP_ALLOC && !predicted.ok) n_full++;
        if (tsp_pkg::op_e'(func_i) == tsp_pkg::OP_GET && predicted.ok) n_hits++;
        if (predicted.cnt > peak_count) peak_count = 32'(predicted.cnt);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycles, answer_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    tsp_pkg::op_e op_sel;
    logic [3:0]   t_sel;
    logic [4:0]   idx_sel;
    logic [4:0]   nth_sel;
    int unsigned  r;
    int unsigned  w_alloc;
    int unsigned  w_free;
    int unsigned  w_count;
    int unsigned  t_base;
    int unsigned  t_span;
    bit           gaps_on;

    for (int s = 0; s < POOL_SLOTS; s++) begin
      pool_used[s] = 1'b0;
      pool_tag[s]  = '0;
    end
    foreach (n_op[k]) n_op[k] = 0;

    // Directed table; unused fields carry odd values that must be ignored
    stim_rows.push_back(mk_row(tsp_pkg::OP_COUNT, 4'd0,  5'd31, 5'd31, 1'b1, 1'b0, 5'd0, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_GET,   4'd0,  5'd31, 5'd0,  1'b1, 1'b0, 5'd0, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_FREE,  4'd15, 5'd31, 5'd31, 1'b1, 1'b0, 5'd0, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_ALLOC, 4'd15, 5'd31, 5'd31, 1'b1, 1'b1, 5'd0, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_ALLOC, 4'd0,  5'd0,  5'd0,  1'b1, 1'b1, 5'd1, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_ALLOC, 4'd15, 5'd7,  5'd3,  1'b1, 1'b1, 5'd2, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_ALLOC, 4'd10, 5'd21, 5'd10, 1'b1, 1'b1, 5'd3, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_ALLOC, 4'd5,  5'd10, 5'd21, 1'b1, 1'b1, 5'd4, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_COUNT, 4'd15, 5'd0,  5'd0,  1'b1, 1'b0, 5'd0, 6'd2));
    stim_rows.push_back(mk_row(tsp_pkg::OP_GET,   4'd15, 5'd0,  5'd1,  1'b1, 1'b1, 5'd2, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_GET,   4'd15, 5'd0,  5'd31, 1'b1, 1'b0, 5'd0, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_GET,   4'd5,  5'd31, 5'd0,  1'b1, 1'b1, 5'd4, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_FREE,  4'd0,  5'd1,  5'd0,  1'b1, 1'b0, 5'd0, 6'd0));
    // freeing a slot that is already free changes nothing
    stim_rows.push_back(mk_row(tsp_pkg::OP_FREE,  4'd0,  5'd1,  5'd0,  1'b1, 1'b0, 5'd0, 6'd0));
    // the stale tag of a freed slot is never counted
    stim_rows.push_back(mk_row(tsp_pkg::OP_COUNT, 4'd0,  5'd1,  5'd0,  1'b1, 1'b0, 5'd0, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_ALLOC, 4'd7,  5'd0,  5'd0,  1'b1, 1'b1, 5'd1, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_GET,   4'd0,  5'd0,  5'd0,  1'b1, 1'b0, 5'd0, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_GET,   4'd7,  5'd0,  5'd0,  1'b1, 1'b1, 5'd1, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_FREE,  4'd15, 5'd0,  5'd31, 1'b1, 1'b0, 5'd0, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_GET,   4'd15, 5'd0,  5'd0,  1'b1, 1'b1, 5'd2, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_ALLOC, 4'd3,  5'd16, 5'd16, 1'b0, 1'b0, 5'd0, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_COUNT, 4'd10, 5'd0,  5'd0,  1'b0, 1'b0, 5'd0, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_GET,   4'd3,  5'd0,  5'd1,  1'b0, 1'b0, 5'd0, 6'd0));
    stim_rows.push_back(mk_row(tsp_pkg::OP_FREE,  4'd0,  5'd16, 5'd0,  1'b0, 1'b0, 5'd0, 6'd0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[k])
      issue_request(stim_rows[k].op, stim_rows[k].etype, stim_rows[k].sidx,
                    stim_rows[k].nth, stim_rows[k].pinned, stim_rows[k].want, gap_len(1));

    // Random phases: fill, drain, few types, churn
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin w_alloc = 60; w_free = 10; w_count = 15; t_base = 15; t_span = 1;
                 gaps_on = 1; end
        1: begin w_alloc = 30; w_free = 40; w_count = 15; t_base = 0;  t_span = 16;
                 gaps_on = 1; end
        2: begin w_alloc = 45; w_free = 25; w_count = 10; t_base = 0;  t_span = 2;
                 gaps_on = 0; end
        3: begin w_alloc = 50; w_free = 20; w_count = 15; t_base = 0;  t_span = 16;
                 gaps_on = 1; end
        4: begin w_alloc = 20; w_free = 50; w_count = 15; t_base = 12; t_span = 4;
                 gaps_on = 1; end
        default: begin w_alloc = 25; w_free = 25; w_count = 25; t_base = 0; t_span = 16;
                       gaps_on = 1; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < w_alloc) op_sel = tsp_pkg::OP_ALLOC;
        else if (r < w_alloc + w_free) op_sel = tsp_pkg::OP_FREE;
        else if (r < w_alloc + w_free + w_count) op_sel = tsp_pkg::OP_COUNT;
        else op_sel = tsp_pkg::OP_GET;
        t_sel   = 4'(t_base + $urandom_range(0, t_span - 1));
        idx_sel = 5'($urandom);
        nth_sel = 5'($urandom);
        // mostly aimed requests; the rest keep fully random fields
        if ($urandom_range(0, 9) != 0) begin
          if (op_sel == tsp_pkg::OP_FREE) idx_sel = pick_used_slot();
          if (op_sel == tsp_pkg::OP_GET) nth_sel = 5'($urandom_range(0, tally_type(t_sel)));
        end else begin
          t_sel = 4'($urandom);
        end
        issue_request(op_sel, t_sel, idx_sel, nth_sel, 1'b0, '0, gap_len(gaps_on));
      end
    end

    start_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("requests: %0d allocate (%0d on a full pool), %0d free, %0d count, %0d get",
             n_op[tsp_pkg::OP_ALLOC], n_full, n_op[tsp_pkg::OP_FREE],
             n_op[tsp_pkg::OP_COUNT], n_op[tsp_pkg::OP_GET]);
    $display("gets that found a slot: %0d, largest type count: %0d, mismatches: %0d",
             n_hits, peak_count, mismatches);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_front.sv
hw/rtl/tsp_engine.sv
hw/rtl/typed_slot_pool.sv
bench/testbench.sv
